/* hdl/btpc_pkg.sv */
// Shared types, constants and the divider step for the barometer compensation pipeline.
`timescale 1ns / 1ps
package btpc_pkg;

    localparam int NUM_W = 64;
    localparam int DEN_W = 31;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;

    // calibration register indexes; REG_NONE addresses no register
    localparam logic [2:0] REG_T1   = 3'd0;
    localparam logic [2:0] REG_T23  = 3'd1;
    localparam logic [2:0] REG_P1   = 3'd2;
    localparam logic [2:0] REG_P23  = 3'd3;
    localparam logic [2:0] REG_P45  = 3'd4;
    localparam logic [2:0] REG_P67  = 3'd5;
    localparam logic [2:0] REG_P89  = 3'd6;
    localparam logic [2:0] REG_NONE = 3'd7;

    // Temperature results that ride along with the pressure path
    typedef struct packed {
        logic signed [15:0] centi;
        logic signed [31:0] fine;
    } side_t;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic nbit,
                                                input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        t = {rem, nbit};
        diff = t - {1'b0, den};
        if (t >= {1'b0, den})
            return {1'b1, diff[DEN_W-1:0]};
        else
            return {1'b0, t[DEN_W-1:0]};
    endfunction

endpackage

/* hdl/btpc_div.sv */
// Pipelined signed 64 by 31 bit divider, truncating toward zero, two quotient bits per stage.
`timescale 1ns / 1ps
module btpc_div
    import btpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    input  side_t                   in_side,
    output logic                    out_vld,
    output logic signed [NUM_W-1:0] quo,
    output logic                    out_nz,
    output side_t                   out_side
);

    logic [DIV_STAGES:0] vld_reg;
    logic [DEN_W-1:0]    rem_reg [0:DIV_STAGES];
    logic [NUM_W-1:0]    wrk_reg [0:DIV_STAGES];
    logic [DEN_W-1:0]    dv_reg  [0:DIV_STAGES];
    logic                neg_reg [0:DIV_STAGES];
    logic                nz_reg  [0:DIV_STAGES];
    side_t               side_reg [0:DIV_STAGES];

    logic                    out_vld_reg;
    logic signed [NUM_W-1:0] quo_reg;
    logic signed [NUM_W-1:0] quo_next;
    logic                    nz_out_reg;
    side_t                   side_out_reg;

    logic [NUM_W-1:0] nmag_next;
    logic [DEN_W-1:0] dmag_next;

    assign nmag_next = num[NUM_W-1] ? (NUM_W'(0) - NUM_W'(num)) : NUM_W'(num);
    assign dmag_next = den[DEN_W-1] ? (DEN_W'(0) - DEN_W'(den)) : DEN_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_STAGES-1:0], in_vld};
    end

    // Take magnitudes and sign of the quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            wrk_reg[0]  <= nmag_next;
            dv_reg[0]   <= dmag_next;
            neg_reg[0]  <= num[NUM_W-1] ^ den[DEN_W-1];
            nz_reg[0]   <= (den != '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] wrk_next;

        always_comb
        begin
            logic [DEN_W:0] r;
            rem_next = rem_reg[k];
            wrk_next = wrk_reg[k];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                r = div_step(rem_next, wrk_next[NUM_W-1], dv_reg[k]);
                rem_next = r[DEN_W-1:0];
                wrk_next = {wrk_next[NUM_W-2:0], r[DEN_W]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                wrk_reg[k+1]  <= wrk_next;
                dv_reg[k+1]   <= dv_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                nz_reg[k+1]   <= nz_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Restore the sign; the most negative value wraps onto itself
    assign quo_next = neg_reg[DIV_STAGES] ? $signed(NUM_W'(0) - wrk_reg[DIV_STAGES])
                                          : $signed(wrk_reg[DIV_STAGES]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg      <= quo_next;
            nz_out_reg   <= nz_reg[DIV_STAGES];
            side_out_reg <= side_reg[DIV_STAGES];
        end
    end

    assign out_vld  = out_vld_reg;
    assign quo      = quo_reg;
    assign out_nz   = nz_out_reg;
    assign out_side = side_out_reg;

endmodule

/* hdl/baro_temp_pressure_compensation_unit.sv */
// Top level: temperature and pressure compensation pipeline with its calibration registers.
// Throughput: one word per cycle; 11 front stages, 34 divider stages (sign setup, 32 stages
// of two quotient bits, sign restore), 6 back stages. The whole pipe holds while a result waits.
// Reset: rst_n clears all valid bits and sets every calibration register to zero.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_unit
    import btpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] temperature_centi,
    output logic signed [31:0] fine_temperature,
    output logic [23:0]        pressure_pa,
    output logic               pressure_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic signed [31:0] TFINE_OFFSET = 32'sd128000;
    localparam logic signed [31:0] TEMP_ROUND   = 32'sd128;
    localparam logic [20:0]        PRESS_BASE   = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE  = 12'd3125;
    localparam int                 FRONT        = 11;
    localparam int                 BACK         = 6;

    // calibration registers
    logic [15:0] t1_reg;
    logic [31:0] t23_reg;
    logic [15:0] p1_reg;
    logic [31:0] p23_reg;
    logic [31:0] p45_reg;
    logic [31:0] p67_reg;
    logic [31:0] p89_reg;

    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t2 = $signed(t23_reg[15:0]);
    assign t3 = $signed(t23_reg[31:16]);
    assign p2 = $signed(p23_reg[15:0]);
    assign p3 = $signed(p23_reg[31:16]);
    assign p4 = $signed(p45_reg[15:0]);
    assign p5 = $signed(p45_reg[31:16]);
    assign p6 = $signed(p67_reg[15:0]);
    assign p7 = $signed(p67_reg[31:16]);
    assign p8 = $signed(p89_reg[15:0]);
    assign p9 = $signed(p89_reg[31:16]);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t23_reg <= '0;
            p1_reg  <= '0;
            p23_reg <= '0;
            p45_reg <= '0;
            p67_reg <= '0;
            p89_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_T1:  t1_reg  <= cfg_data[15:0];
                REG_T23: t23_reg <= cfg_data;
                REG_P1:  p1_reg  <= cfg_data[15:0];
                REG_P23: p23_reg <= cfg_data;
                REG_P45: p45_reg <= cfg_data;
                REG_P67: p67_reg <= cfg_data;
                REG_P89: p89_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold every pipeline stage while the output word waits
    logic en;
    logic out_vld_reg;
    assign en = !(out_vld_reg && !out_ready);
    assign in_ready = en;

    logic [FRONT-1:0] s_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= '0;
        else if (en)
            s_vld_reg <= {s_vld_reg[FRONT-2:0], in_valid};
    end

    // fine temperature and centi-degrees carried along the front stages
    logic signed [31:0] fine_reg  [3:FRONT];
    logic signed [15:0] centi_reg [4:FRONT];
    logic [19:0]        adcp_reg  [1:8];

    // stage 1: first temperature products
    logic signed [17:0] tdiff, dt;
    logic signed [35:0] dd_full;
    logic signed [33:0] s1_ta_reg, s1_ta_next;
    logic [31:0]        s1_dd_reg, s1_dd_next;
    assign tdiff = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1_reg, 1'b0});
    assign dt = $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, t1_reg});
    assign s1_ta_next = tdiff * t2;
    assign dd_full = dt * dt;
    assign s1_dd_next = dd_full[31:0];

    // stage 2
    logic signed [20:0] ddh;
    logic signed [22:0] s2_ta_reg, s2_ta_next;
    logic signed [36:0] s2_tb_reg, s2_tb_next;
    assign s2_ta_next = 23'(s1_ta_reg >>> 11);
    assign ddh = $signed({1'b0, s1_dd_reg[31:12]});
    assign s2_tb_next = ddh * t3;

    // stage 3: fine temperature
    logic signed [31:0] s3_fine_next;
    assign s3_fine_next = 32'(s2_ta_reg) + 32'(s2_tb_reg >>> 14);

    // stage 4: centi-degrees and pressure offset term
    logic signed [31:0] c5, cdeg;
    logic signed [15:0] s4_centi_next;
    logic signed [25:0] s4_fa_reg, s4_fa_next;
    assign c5 = (fine_reg[3] <<< 2) + fine_reg[3] + TEMP_ROUND;
    assign cdeg = c5 >>> 8;
    always_comb
    begin
        if (cdeg > 32'sd32767)
            s4_centi_next = 16'sh7fff;
        else if (cdeg < -32'sd32768)
            s4_centi_next = 16'sh8000;
        else
            s4_centi_next = cdeg[15:0];
    end
    assign s4_fa_next = 26'(fine_reg[3] - TFINE_OFFSET);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fine_reg[3] <= s3_fine_next;
            for (int k = 4; k <= FRONT; k++)
                fine_reg[k] <= fine_reg[k-1];
            centi_reg[4] <= s4_centi_next;
            for (int k = 5; k <= FRONT; k++)
                centi_reg[k] <= centi_reg[k-1];
            adcp_reg[1] <= raw_pressure;
            for (int k = 2; k <= 8; k++)
                adcp_reg[k] <= adcp_reg[k-1];
        end
    end

    // stage 5: products of the offset
    logic signed [51:0] aa_full;
    logic [49:0]        s5_aa_reg, s5_aa_next;
    logic signed [41:0] s5_ap5_reg, s5_ap5_next, s5_ap2_reg, s5_ap2_next;
    assign aa_full = s4_fa_reg * s4_fa_reg;
    assign s5_aa_next = aa_full[49:0];
    assign s5_ap5_next = s4_fa_reg * p5;
    assign s5_ap2_next = s4_fa_reg * p2;

    // stage 6: split square times P6 and P3
    logic signed [32:0] aa_lo;
    logic signed [18:0] aa_hi;
    logic signed [48:0] s6_lo6_reg, s6_lo6_next, s6_lo3_reg, s6_lo3_next;
    logic signed [34:0] s6_hi6_reg, s6_hi6_next, s6_hi3_reg, s6_hi3_next;
    logic signed [41:0] s6_ap5_reg, s6_ap2_reg;
    assign aa_lo = $signed({1'b0, s5_aa_reg[31:0]});
    assign aa_hi = $signed({1'b0, s5_aa_reg[49:32]});
    assign s6_lo6_next = aa_lo * p6;
    assign s6_hi6_next = aa_hi * p6;
    assign s6_lo3_next = aa_lo * p3;
    assign s6_hi3_next = aa_hi * p3;

    // stage 7: combine the partial products
    logic signed [63:0] s7_b1_reg, s7_b1_next, s7_c1_reg, s7_c1_next;
    logic signed [41:0] s7_ap5_reg, s7_ap2_reg;
    assign s7_b1_next = (64'(s6_hi6_reg) <<< 32) + 64'(s6_lo6_reg);
    assign s7_c1_next = (64'(s6_hi3_reg) <<< 32) + 64'(s6_lo3_reg);

    // stage 8: numerator offset and divisor base
    logic signed [63:0] s8_b_reg, s8_b_next, s8_y_reg, s8_y_next;
    assign s8_b_next = s7_b1_reg + (64'(s7_ap5_reg) <<< 17) + (64'(p4) <<< 35);
    assign s8_y_next = (s7_c1_reg >>> 8) + (64'(s7_ap2_reg) <<< 12) + (64'sd1 <<< 47);

    // stage 9: divisor times P1 in halves, raw numerator
    logic [47:0] s9_ylo_reg, s9_ylo_next, yhi_full;
    logic [31:0] s9_yhi_reg, s9_yhi_next;
    logic [20:0] praw;
    logic [63:0] s9_pnum_reg, s9_pnum_next;
    assign s9_ylo_next = s8_y_reg[31:0] * p1_reg;
    assign yhi_full = s8_y_reg[63:32] * p1_reg;
    assign s9_yhi_next = yhi_full[31:0];
    assign praw = PRESS_BASE - {1'b0, adcp_reg[8]};
    assign s9_pnum_next = ({43'd0, praw} << 31) - s8_b_reg;

    // stage 10: divisor, numerator times scale in halves
    logic [63:0]        zsum;
    logic signed [30:0] s10_den_reg, s10_den_next;
    logic [43:0]        s10_nlo_reg, s10_nlo_next, nhi_full;
    logic [31:0]        s10_nhi_reg, s10_nhi_next;
    assign zsum = {s9_yhi_reg, 32'd0} + {16'd0, s9_ylo_reg};
    assign s10_den_next = $signed(zsum[63:33]);
    assign s10_nlo_next = s9_pnum_reg[31:0] * PRESS_SCALE;
    assign nhi_full = s9_pnum_reg[63:32] * PRESS_SCALE;
    assign s10_nhi_next = nhi_full[31:0];

    // stage 11: numerator
    logic signed [63:0] s11_num_reg, s11_num_next;
    logic signed [30:0] s11_den_reg;
    assign s11_num_next = $signed({s10_nhi_reg, 32'd0} + {20'd0, s10_nlo_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ta_reg   <= s1_ta_next;
            s1_dd_reg   <= s1_dd_next;
            s2_ta_reg   <= s2_ta_next;
            s2_tb_reg   <= s2_tb_next;
            s4_fa_reg   <= s4_fa_next;
            s5_aa_reg   <= s5_aa_next;
            s5_ap5_reg  <= s5_ap5_next;
            s5_ap2_reg  <= s5_ap2_next;
            s6_lo6_reg  <= s6_lo6_next;
            s6_hi6_reg  <= s6_hi6_next;
            s6_lo3_reg  <= s6_lo3_next;
            s6_hi3_reg  <= s6_hi3_next;
            s6_ap5_reg  <= s5_ap5_reg;
            s6_ap2_reg  <= s5_ap2_reg;
            s7_b1_reg   <= s7_b1_next;
            s7_c1_reg   <= s7_c1_next;
            s7_ap5_reg  <= s6_ap5_reg;
            s7_ap2_reg  <= s6_ap2_reg;
            s8_b_reg    <= s8_b_next;
            s8_y_reg    <= s8_y_next;
            s9_ylo_reg  <= s9_ylo_next;
            s9_yhi_reg  <= s9_yhi_next;
            s9_pnum_reg <= s9_pnum_next;
            s10_den_reg <= s10_den_next;
            s10_nlo_reg <= s10_nlo_next;
            s10_nhi_reg <= s10_nhi_next;
            s11_num_reg <= s11_num_next;
            s11_den_reg <= s10_den_reg;
        end
    end

    // divider
    side_t              div_side_in, div_side;
    logic               div_vld, div_nz;
    logic signed [63:0] div_quo;
    assign div_side_in.centi = centi_reg[FRONT];
    assign div_side_in.fine  = fine_reg[FRONT];

    btpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_vld_reg[FRONT-1]),
        .num      (s11_num_reg),
        .den      (s11_den_reg),
        .in_side  (div_side_in),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .out_nz   (div_nz),
        .out_side (div_side)
    );

    logic [BACK-2:0] p_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg   <= {p_vld_reg[BACK-3:0], div_vld};
            out_vld_reg <= p_vld_reg[BACK-2];
        end
    end

    // back stage 1: P9 times scaled quotient, P8 term
    logic signed [50:0] qs;
    logic signed [66:0] m_full;
    logic signed [79:0] dprod;
    logic [63:0]        b1_m_reg, b1_m_next;
    logic signed [63:0] b1_d_reg, b1_d_next, b1_q_reg;
    assign qs = div_quo[63:13];
    assign m_full = p9 * qs;
    assign b1_m_next = m_full[63:0];
    assign dprod = p8 * div_quo;
    assign b1_d_next = $signed(dprod[63:0]) >>> 19;

    // back stage 2: low 64 bits of m times scaled quotient, in partial products
    logic [63:0] qsx;
    logic [63:0] cr1, cr2;
    logic [63:0] b2_ll_reg, b2_ll_next;
    logic [31:0] b2_cr_reg, b2_cr_next;
    logic signed [63:0] b2_q_reg, b2_d_reg;
    assign qsx = {{13{b1_q_reg[63]}}, b1_q_reg[63:13]};
    assign b2_ll_next = b1_m_reg[31:0] * qsx[31:0];
    assign cr1 = b1_m_reg[31:0] * qsx[63:32];
    assign cr2 = b1_m_reg[63:32] * qsx[31:0];
    assign b2_cr_next = cr1[31:0] + cr2[31:0];

    // back stage 3
    logic signed [63:0] b3_b_reg, b3_b_next, b3_q_reg, b3_d_reg;
    assign b3_b_next = $signed(b2_ll_reg + {b2_cr_reg, 32'd0}) >>> 25;

    // back stage 4
    logic signed [63:0] b4_sum_reg, b4_sum_next;
    assign b4_sum_next = b3_q_reg + b3_b_reg + b3_d_reg;

    // back stage 5
    logic signed [63:0] b5_r_reg, b5_r_next;
    assign b5_r_next = (b4_sum_reg >>> 8) + (64'(p7) <<< 4);

    // back stage 6: clamp to the output range, or zero when the divisor was zero
    logic [23:0] pa_next;
    side_t       bside_reg [1:BACK];
    logic        bnz_reg   [1:BACK];
    logic [23:0] pa_reg;
    always_comb
    begin
        if (!bnz_reg[BACK-1] || b5_r_reg[63])
            pa_next = '0;
        else if (|b5_r_reg[62:32])
            pa_next = 24'hFFFFFF;
        else
            pa_next = b5_r_reg[31:8];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_m_reg   <= b1_m_next;
            b1_d_reg   <= b1_d_next;
            b1_q_reg   <= div_quo;
            b2_ll_reg  <= b2_ll_next;
            b2_cr_reg  <= b2_cr_next;
            b2_q_reg   <= b1_q_reg;
            b2_d_reg   <= b1_d_reg;
            b3_b_reg   <= b3_b_next;
            b3_q_reg   <= b2_q_reg;
            b3_d_reg   <= b2_d_reg;
            b4_sum_reg <= b4_sum_next;
            b5_r_reg   <= b5_r_next;
            pa_reg     <= pa_next;
            bside_reg[1] <= div_side;
            bnz_reg[1]   <= div_nz;
            for (int k = 2; k <= BACK; k++)
            begin
                bside_reg[k] <= bside_reg[k-1];
                bnz_reg[k]   <= bnz_reg[k-1];
            end
        end
    end

    assign out_valid         = out_vld_reg;
    assign temperature_centi = bside_reg[BACK].centi;
    assign fine_temperature  = bside_reg[BACK].fine;
    assign pressure_pa       = pa_reg;
    assign pressure_valid    = bnz_reg[BACK];

endmodule

/* hdl/btpc_port_chk.sv */
// Port-level checks for the compensation unit, bound to its top level.
`timescale 1ns / 1ps
module btpc_port_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] temperature_centi,
    input logic signed [31:0] fine_temperature,
    input logic [23:0]        pressure_pa,
    input logic               pressure_valid
);

    logic signed [35:0] c5;
    logic signed [35:0] cdeg;
    logic signed [15:0] centi_exp;

    assign c5 = (36'(fine_temperature) <<< 2) + 36'(fine_temperature) + 36'sd128;
    assign cdeg = c5 >>> 8;
    always_comb
    begin
        if (cdeg > 36'sd32767)
            centi_exp = 16'sh7fff;
        else if (cdeg < -36'sd32768)
            centi_exp = 16'sh8000;
        else
            centi_exp = cdeg[15:0];
    end

    // a waiting word must hold: out_valid stays up, pressure_pa and fine_temperature are stable
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressure_pa)
                                    && $stable(fine_temperature))
        else $error("output word changed while stalled");

    // no intake while the output is stalled
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressure_valid |-> pressure_pa == 24'd0)
        else $error("pressure nonzero with zero divisor");

    a_centi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_centi == centi_exp)
        else $error("centi-degrees do not match fine temperature");

endmodule

bind baro_temp_pressure_compensation_unit btpc_port_chk u_port_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .fine_temperature  (fine_temperature),
    .pressure_pa       (pressure_pa),
    .pressure_valid    (pressure_valid)
);
